>>> rtl/scwe_pkg.sv
// Shared types and constants for the SPI checksummed word exchange.
`timescale 1ns / 1ps
`default_nettype none

package scwe_pkg;

  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DataWidth = 32;

  localparam logic [7:0] HeaderReset  = 8'hA5;
  localparam logic [7:0] PrepareReset = 8'h5A;

  // Command codes carried in the cmd field
  localparam logic CmdStart = 1'b0;
  localparam logic CmdByte  = 1'b1;

  // Register indexes (paddr bit 2)
  localparam logic RegHeader  = 1'b0;
  localparam logic RegPrepare = 1'b1;

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_PREP = 6'b000010,
    PH_HDR  = 6'b000100,
    PH_HI   = 6'b001000,
    PH_LO   = 6'b010000,
    PH_SUM  = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [7:0] header;
    logic [7:0] prepare;
  } cfg_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] send_word;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic        select_active;
    logic        done_res;
    logic        frame_ok;
    logic [15:0] received_word;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/scwe_regs.sv
// APB register file holding the frame header and prepare bytes.
`timescale 1ns / 1ps
`default_nettype none

module scwe_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [scwe_pkg::AddrWidth-1:0] paddr,
  input  wire logic [scwe_pkg::DataWidth-1:0] pwdata,
  output logic      [scwe_pkg::DataWidth-1:0] prdata,
  output logic                                pready,
  output scwe_pkg::cfg_t                      cfg_o
);

  scwe_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;
  logic           reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        scwe_pkg::RegHeader:  cfg_d.header  = pwdata[7:0];
        scwe_pkg::RegPrepare: cfg_d.prepare = pwdata[7:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header  <= scwe_pkg::HeaderReset;
      cfg_q.prepare <= scwe_pkg::PrepareReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      scwe_pkg::RegHeader:  prdata[7:0] = cfg_q.header;
      scwe_pkg::RegPrepare: prdata[7:0] = cfg_q.prepare;
      default: prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/scwe_frame_ctrl.sv
// Exchange sequencer: phase tracking, byte selection and reply check.
`timescale 1ns / 1ps
`default_nettype none

module scwe_frame_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,    // consume one item this cycle
  input  wire scwe_pkg::item_t item_i,
  input  wire scwe_pkg::cfg_t  cfg_i,
  output logic                 res_valid_o,
  output scwe_pkg::res_t       res_o
);

  scwe_pkg::phase_e phase_q, phase_d;
  logic [15:0]      word_q, word_d;
  logic [7:0]       reply_q [3];
  logic [7:0]       reply_d [3];
  logic [15:0]      held_q, held_d;
  logic             busy;
  logic [7:0]       hi_byte, lo_byte, expect_sum;
  logic             ok;

  assign hi_byte    = word_q[15:8];
  assign lo_byte    = word_q[7:0];
  assign expect_sum = reply_q[0] ^ reply_q[1] ^ reply_q[2];
  assign ok         = (reply_q[0] == cfg_i.header) && (item_i.rx_byte == expect_sum);

  always_comb begin
    case (phase_q)
      scwe_pkg::PH_PREP, scwe_pkg::PH_HDR, scwe_pkg::PH_HI,
      scwe_pkg::PH_LO, scwe_pkg::PH_SUM: busy = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    word_d      = word_q;
    reply_d     = reply_q;
    held_d      = held_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_i) begin
      if (item_i.cmd == scwe_pkg::CmdStart) begin
        if (!busy) begin
          word_d              = item_i.send_word;
          phase_d             = scwe_pkg::PH_PREP;
          res_valid_o         = 1'b1;
          res_o.tx_byte       = cfg_i.prepare;
          res_o.tx_valid      = 1'b1;
          res_o.select_active = 1'b1;
        end
      end else if (busy) begin
        res_valid_o         = 1'b1;
        res_o.tx_valid      = 1'b1;
        res_o.select_active = 1'b1;
        case (phase_q)
          scwe_pkg::PH_PREP: begin
            phase_d       = scwe_pkg::PH_HDR;
            res_o.tx_byte = cfg_i.header;
          end
          scwe_pkg::PH_HDR: begin
            reply_d[0]    = item_i.rx_byte;
            phase_d       = scwe_pkg::PH_HI;
            res_o.tx_byte = hi_byte;
          end
          scwe_pkg::PH_HI: begin
            reply_d[1]    = item_i.rx_byte;
            phase_d       = scwe_pkg::PH_LO;
            res_o.tx_byte = lo_byte;
          end
          scwe_pkg::PH_LO: begin
            reply_d[2]    = item_i.rx_byte;
            phase_d       = scwe_pkg::PH_SUM;
            res_o.tx_byte = cfg_i.header ^ hi_byte ^ lo_byte;
          end
          default: begin
            // checksum beat ends the exchange
            if (ok) begin
              held_d = {reply_q[1], reply_q[2]};
            end
            phase_d             = scwe_pkg::PH_IDLE;
            res_o.tx_valid      = 1'b0;
            res_o.select_active = 1'b0;
            res_o.done_res      = 1'b1;
            res_o.frame_ok      = ok;
          end
        endcase
      end
    end
    res_o.received_word = held_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= scwe_pkg::PH_IDLE;
      word_q  <= '0;
      held_q  <= '0;
    end else begin
      phase_q <= phase_d;
      word_q  <= word_d;
      held_q  <= held_d;
    end
  end

  // reply bytes are always written before they are read
  always_ff @(posedge clk_i) begin
    reply_q <= reply_d;
  end

endmodule

`default_nettype wire

>>> rtl/spi_checksummed_word_exchange.sv
// Top level of the SPI checksummed word exchange: channels, pipeline registers.
`timescale 1ns / 1ps
`default_nettype none

// SPI master sequencer for a framed 16-bit word exchange. A start beat
// (cmd 0) asks for the prepare byte; each byte-done beat (cmd 1) asks for the
// header, high byte, low byte and XOR checksum in turn, and the fifth byte-done
// beat ends the exchange with done_res and frame_ok. Starts while busy and
// byte-done beats while idle are dropped without a result. A beat is taken
// into an input register, then goes through one level of sequencer logic into
// the result register, one beat per cycle sustained while out_ready_i allows.
// The input register advances whenever the result register is empty or being
// drained, so throughput is set only by out_ready_i. The header and prepare
// bytes sit at APB addresses 0x0 and 0x4; write them only while no exchange
// is in progress.
module spi_checksummed_word_exchange (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input channel
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           cmd_i,
  input  wire logic [15:0]                    send_word_i,
  input  wire logic [7:0]                     rx_byte_i,
  // result channel
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [7:0]                     tx_byte_o,
  output logic                                tx_valid_o,
  output logic                                select_active_o,
  output logic                                done_res_o,
  output logic                                frame_ok_o,
  output logic      [15:0]                    received_word_o,
  // configuration
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [scwe_pkg::AddrWidth-1:0] paddr,
  input  wire logic [scwe_pkg::DataWidth-1:0] pwdata,
  output logic      [scwe_pkg::DataWidth-1:0] prdata,
  output logic                                pready
);

  scwe_pkg::cfg_t  cfg;
  scwe_pkg::item_t item_q;
  logic            item_vld_q;
  logic            step;
  logic            res_vld;
  scwe_pkg::res_t  res;
  scwe_pkg::res_t  out_q;
  logic            out_vld_q;
  logic            out_free;

  scwe_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign out_free   = !out_vld_q || out_ready_i;
  assign step       = item_vld_q && out_free;
  assign in_ready_o = !item_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      item_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.cmd       <= cmd_i;
      item_q.send_word <= send_word_i;
      item_q.rx_byte   <= rx_byte_i;
    end
  end

  scwe_frame_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (item_q),
    .cfg_i       (cfg),
    .res_valid_o (res_vld),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_vld) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign tx_byte_o       = out_q.tx_byte;
  assign tx_valid_o      = out_q.tx_valid;
  assign select_active_o = out_q.select_active;
  assign done_res_o      = out_q.done_res;
  assign frame_ok_o      = out_q.frame_ok;
  assign received_word_o = out_q.received_word;

endmodule

`default_nettype wire
